### rtl/pgbs_pkg.sv
package pgbs_pkg;

    // Grid limits and per-cell widths.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_DEPTH  = 256;
    localparam int COUNT_BITS = 16;
    localparam int CELLS      = MAX_WIDTH * MAX_DEPTH;
    localparam int IDX_BITS   = $clog2(CELLS);
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Z_BITS     = $clog2(MAX_DEPTH);
    localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int D_BITS     = $clog2(MAX_DEPTH + 1);
    localparam int ZW_BITS    = Z_BITS + W_BITS;
    localparam int AREA_BITS  = W_BITS + D_BITS;
    localparam int AXES       = 3;

    // Statistics arithmetic.
    localparam int SUMSQ_BITS = 48;
    localparam int ACC_BITS   = SUMSQ_BITS + 2;
    localparam int MEAN_STEPS = 32;
    localparam int VAR_STEPS  = SUMSQ_BITS;
    localparam int STEP_BITS  = $clog2(VAR_STEPS + 1);

    // Configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [31:0] INV_SIZE_RESET = 32'h0001_0000;
    localparam logic [30:0] RADIUS_RESET   = 31'h0001_0000;
    localparam logic [8:0]  GRID_W_RESET   = 9'd256;
    localparam logic [8:0]  GRID_D_RESET   = 9'd256;
    localparam logic [31:0] Q16_MAX        = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_TERRAIN,
        FUNC_PARTICLE,
        FUNC_READ,
        FUNC_CLEAR
    } t_func;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Z,
        CFG_INV_SIZE,
        CFG_RADIUS,
        CFG_GRID_W,
        CFG_GRID_D,
        CFG_STATS_EN
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MULX,
        S_MULZ,
        S_LOC,
        S_ACT,
        S_EVAL,
        S_DIV,
        S_VAR,
        S_MEAN,
        S_ERR,
        S_MUL,
        S_SUM,
        S_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [15:0]        cell_index;
        logic signed [31:0] ground_height;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_in_item;

    typedef struct packed {
        logic               in_grid;
        logic               wet;
        logic signed [31:0] surface_height;
        logic [31:0]        water_depth;
        logic signed [31:0] mean_vx;
        logic signed [31:0] mean_vy;
        logic signed [31:0] mean_vz;
        logic [31:0]        velocity_variance;
        logic [15:0]        particle_total;
        logic               overflow_error;
    } t_out_item;

    // One cell of the water state; mean[0] is x, mean[2] is z.
    typedef struct packed {
        logic [31:0]                surface;
        logic                       wet;
        logic [COUNT_BITS-1:0]      count;
        logic [AXES-1:0][31:0]      mean;
        logic [SUMSQ_BITS-1:0]      sumsq;
    } t_cell;

    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] steps;
    } t_div_ctrl;

endpackage

### rtl/particle_grid_binning_stats_core.sv
// Particle-to-grid binning core. Each input beat is one operation: load a cell's terrain
// height, add a particle, read a cell, or clear a cell; each produces exactly one result
// beat. Items are handled one at a time. A particle that lands in the grid and a read that
// reports variance take longest; they are set by the shared three-lane restoring divider,
// which retires one quotient bit per cycle (32 bits for the running means, 48 for sum of
// squares over count). The next beat can be taken in the cycle after the result is loaded.
// The cell state lives in one synchronous memory of 65536 entries and the terrain in a
// second one; after reset the core sweeps the cell memory to zero, one entry per cycle,
// which holds input ready low until the sweep ends. Configuration writes are taken at any time
// but must only be issued while the core is idle. A result waiting in the output register
// does not block the next item from being accepted.
module particle_grid_binning_stats_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pgbs_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pgbs_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [pgbs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pgbs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import pgbs_pkg::*;

    // Configuration registers.
    logic [31:0]            r_origin_x;
    logic [31:0]            r_origin_z;
    logic [31:0]            r_inv;
    logic [30:0]            r_radius;
    logic [8:0]             r_grid_w;
    logic [8:0]             r_grid_d;
    logic                   r_stats;

    // Sequencer and working registers.
    t_state                 r_state, n_state;
    t_in_item               r_item;
    logic [32:0]            r_dx, r_dz;
    logic [31:0]            r_px, r_pz;
    logic [IDX_BITS-1:0]    r_idx;
    logic                   r_hit;
    logic [IDX_BITS-1:0]    r_clr_addr;
    t_cell                  r_cell;
    logic [31:0]            r_terr;
    logic [COUNT_BITS-1:0]  r_next;
    logic [31:0]            r_surf;
    logic [AXES-1:0]        r_dneg;
    logic [AXES-1:0][31:0]  r_ma, r_mb, r_nm;
    logic [1:0]             r_axis;
    logic                   r_pv;
    logic [SUMSQ_BITS-1:0]  r_prod;
    logic [ACC_BITS-1:0]    r_acc;
    t_out_item              r_res, r_out;
    logic                   r_out_valid;
    logic                   r_err;

    // Memories.
    t_cell                  r_cell_mem [CELLS];
    logic [31:0]            r_terr_mem [CELLS];

    // Combinational signals.
    logic [W_BITS-1:0]      w_eff;
    logic [D_BITS-1:0]      d_eff;
    logic [AREA_BITS-1:0]   area;
    logic [ZW_BITS-1:0]     zw;
    logic                   x_ok, z_ok;
    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p;
    logic                   accept, out_load;
    logic                   mem_we, terr_we, rd_en;
    logic [IDX_BITS-1:0]    mem_waddr;
    t_cell                  mem_wdata;
    logic [AXES-1:0][31:0]  vel;
    logic [AXES-1:0][32:0]  dvel;
    logic [AXES-1:0][31:0]  dmag;
    logic [AXES-1:0][32:0]  nm_full;
    logic [AXES-1:0][32:0]  evel;
    logic [32:0]            surf_sum;
    logic [31:0]            surf_sat;
    logic                   cell_full, read_wet, var_run;
    t_div_ctrl              div_ctrl;
    logic [COUNT_BITS-1:0]  div_divisor;
    logic [AXES-1:0][SUMSQ_BITS-1:0] div_dividend, div_quot;
    logic                   div_busy, div_done;

    // Grid size as used: zero acts as one, anything above the maximum acts as the maximum.
    always_comb begin
        if (r_grid_w == '0) begin
            w_eff = W_BITS'(1);
        end else if (32'(r_grid_w) > MAX_WIDTH) begin
            w_eff = W_BITS'(MAX_WIDTH);
        end else begin
            w_eff = W_BITS'(r_grid_w);
        end
        if (r_grid_d == '0) begin
            d_eff = D_BITS'(1);
        end else if (32'(r_grid_d) > MAX_DEPTH) begin
            d_eff = D_BITS'(MAX_DEPTH);
        end else begin
            d_eff = D_BITS'(r_grid_d);
        end
        area = AREA_BITS'(w_eff) * AREA_BITS'(d_eff);
    end

    // Cell location. A negative offset is off the grid unless the inverse size is zero,
    // in which case every position lands in cell zero.
    assign x_ok = !(r_dx[32] && (r_inv != '0)) && (r_px < 32'(w_eff));
    assign z_ok = !(r_dz[32] && (r_inv != '0)) && (r_pz < 32'(d_eff));
    assign zw   = ZW_BITS'(r_pz[Z_BITS-1:0]) * ZW_BITS'(w_eff);

    // One 32x32 multiplier serves both cell lookups and the three per-axis product terms.
    always_comb begin
        case (r_state)
            S_MULX: begin
                mul_a = r_dx[32] ? 32'd0 : r_dx[31:0];
                mul_b = r_inv;
            end
            S_MULZ: begin
                mul_a = r_dz[32] ? 32'd0 : r_dz[31:0];
                mul_b = r_inv;
            end
            default: begin
                mul_a = r_ma[r_axis];
                mul_b = r_mb[r_axis];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Per-axis velocity arithmetic.
    assign vel = {r_item.vel_z, r_item.vel_y, r_item.vel_x};

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            dvel[k]    = {vel[k][31], vel[k]} - {r_cell.mean[k][31], r_cell.mean[k]};
            dmag[k]    = dvel[k][32] ? 32'(-dvel[k]) : dvel[k][31:0];
            nm_full[k] = {r_cell.mean[k][31], r_cell.mean[k]} +
                         (r_dneg[k] ? -{1'b0, div_quot[k][31:0]} : {1'b0, div_quot[k][31:0]});
            evel[k]    = {vel[k][31], vel[k]} - {r_nm[k][31], r_nm[k]};
        end
    end

    // Surface candidate: y plus radius, clipped at the largest positive value.
    assign surf_sum  = {r_item.pos_y[31], r_item.pos_y} + {2'b00, r_radius};
    assign surf_sat  = (!surf_sum[32] && surf_sum[31]) ? Q16_MAX : surf_sum[31:0];
    assign cell_full = (r_cell.count == {COUNT_BITS{1'b1}});
    assign read_wet  = r_cell.wet && ($signed(r_cell.surface) > $signed(r_terr));
    assign var_run   = read_wet && r_stats && (r_cell.count != '0);

    assign accept   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_BITS'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIFF;
            end
            S_DIFF:  n_state = S_MULX;
            S_MULX:  n_state = S_MULZ;
            S_MULZ:  n_state = S_LOC;
            S_LOC:   n_state = S_ACT;
            S_ACT: begin
                if (r_hit && (r_item.func == FUNC_PARTICLE || r_item.func == FUNC_READ)) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EVAL: begin
                if (r_item.func == FUNC_PARTICLE) begin
                    n_state = cell_full ? S_DONE : S_DIV;
                end else begin
                    n_state = var_run ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) n_state = (r_item.func == FUNC_PARTICLE) ? S_MEAN : S_VAR;
            end
            S_VAR:   n_state = S_DONE;
            S_MEAN:  n_state = S_ERR;
            S_ERR:   n_state = S_MUL;
            S_MUL: begin
                if (r_axis == 2'(AXES - 1)) n_state = S_SUM;
            end
            S_SUM:   n_state = S_WB;
            S_WB:    n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_ready     = 1'b0;
        mem_we         = 1'b0;
        terr_we        = 1'b0;
        rd_en          = 1'b0;
        mem_waddr      = r_idx;
        mem_wdata      = '0;
        div_ctrl.start = 1'b0;
        div_ctrl.steps = STEP_BITS'(MEAN_STEPS);
        div_divisor    = r_cell.count + COUNT_BITS'(1);
        for (int k = 0; k < AXES; k++) begin
            div_dividend[k] = {dmag[k], (SUMSQ_BITS - 32)'(0)};
        end
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_ACT: begin
                rd_en   = 1'b1;
                terr_we = r_hit && (r_item.func == FUNC_TERRAIN);
                mem_we  = r_hit && (r_item.func == FUNC_CLEAR);
            end
            S_EVAL: begin
                if (r_item.func == FUNC_PARTICLE) begin
                    div_ctrl.start = !cell_full;
                end else begin
                    div_ctrl.start  = var_run;
                    div_ctrl.steps  = STEP_BITS'(VAR_STEPS);
                    div_divisor     = r_cell.count;
                    div_dividend[0] = r_cell.sumsq;
                end
            end
            S_WB: begin
                mem_we            = 1'b1;
                mem_wdata.surface = r_surf;
                mem_wdata.wet     = 1'b1;
                mem_wdata.count   = r_next;
                mem_wdata.mean    = r_nm;
                mem_wdata.sumsq   = (|r_acc[ACC_BITS-1:SUMSQ_BITS]) ?
                                    {SUMSQ_BITS{1'b1}} : r_acc[SUMSQ_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    pgbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_divisor  (div_divisor),
        .i_dividend (div_dividend),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Cell and terrain memories: one write port, registered read of the addressed entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_cell_mem[mem_waddr] <= mem_wdata;
        if (terr_we) r_terr_mem[r_idx] <= r_item.ground_height;
        if (rd_en) begin
            r_cell <= r_cell_mem[r_idx];
            r_terr <= r_terr_mem[r_idx];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
            r_origin_x  <= '0;
            r_origin_z  <= '0;
            r_inv       <= INV_SIZE_RESET;
            r_radius    <= RADIUS_RESET;
            r_grid_w    <= GRID_W_RESET;
            r_grid_d    <= GRID_D_RESET;
            r_stats     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + IDX_BITS'(1);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EVAL && r_item.func == FUNC_PARTICLE && cell_full) begin
                r_err <= 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                    CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                    CFG_INV_SIZE: r_inv      <= i_cfg_data;
                    CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                    CFG_GRID_W:   r_grid_w   <= i_cfg_data[8:0];
                    CFG_GRID_D:   r_grid_d   <= i_cfg_data[8:0];
                    CFG_STATS_EN: r_stats    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        // The overflow flag is the last field of the result and always shows the sticky flag.
        if (out_load) begin
            r_out <= {r_res[$bits(t_out_item)-1:1], r_err};
        end
        case (r_state)
            S_IDLE: begin
                if (accept) r_item <= i_in;
                r_res <= '0;
            end
            S_DIFF: begin
                r_dx <= {r_item.pos_x[31], r_item.pos_x} - {r_origin_x[31], r_origin_x};
                r_dz <= {r_item.pos_z[31], r_item.pos_z} - {r_origin_z[31], r_origin_z};
            end
            S_MULX: r_px <= mul_p[63:32];
            S_MULZ: r_pz <= mul_p[63:32];
            S_LOC: begin
                if (r_item.func == FUNC_PARTICLE) begin
                    r_hit <= x_ok && z_ok;
                    r_idx <= IDX_BITS'(zw) + IDX_BITS'(r_px[X_BITS-1:0]);
                end else begin
                    r_hit <= AREA_BITS'(r_item.cell_index) < area;
                    r_idx <= IDX_BITS'(r_item.cell_index);
                end
            end
            S_EVAL: begin
                r_next <= r_cell.count + COUNT_BITS'(1);
                r_surf <= (!r_cell.wet || $signed(surf_sat) > $signed(r_cell.surface)) ?
                          surf_sat : r_cell.surface;
                r_acc  <= ACC_BITS'(r_cell.sumsq);
                for (int k = 0; k < AXES; k++) begin
                    r_dneg[k] <= dvel[k][32];
                    r_ma[k]   <= dmag[k];
                end
                if (r_item.func == FUNC_READ) begin
                    r_res.particle_total <= 16'(r_cell.count);
                    if (read_wet) begin
                        r_res.wet            <= 1'b1;
                        r_res.surface_height <= r_cell.surface;
                        r_res.water_depth    <= r_cell.surface - r_terr;
                        r_res.mean_vx        <= r_cell.mean[0];
                        r_res.mean_vy        <= r_cell.mean[1];
                        r_res.mean_vz        <= r_cell.mean[2];
                    end
                end
            end
            S_VAR: begin
                r_res.velocity_variance <= (|div_quot[0][SUMSQ_BITS-1:32]) ?
                                           32'hFFFF_FFFF : div_quot[0][31:0];
            end
            S_MEAN: begin
                for (int k = 0; k < AXES; k++) begin
                    r_nm[k] <= nm_full[k][31:0];
                end
            end
            S_ERR: begin
                for (int k = 0; k < AXES; k++) begin
                    r_mb[k] <= evel[k][32] ? 32'(-evel[k]) : evel[k][31:0];
                end
                r_axis <= '0;
                r_pv   <= 1'b0;
            end
            S_MUL: begin
                r_prod <= mul_p[63:16];
                r_pv   <= 1'b1;
                r_axis <= r_axis + 2'd1;
                if (r_pv) r_acc <= r_acc + ACC_BITS'(r_prod);
            end
            S_SUM: r_acc <= r_acc + ACC_BITS'(r_prod);
            S_WB:  r_res.in_grid <= 1'b1;
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A beat taken at the input drops ready until the item has been finished.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input accepted while an item was in flight");

    // The clearing pass writes every cycle and keeps the input closed.
    a_clear_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (mem_we && !o_in_ready))
        else $error("clearing pass stalled or input open");

    // The divider is never restarted while a division runs.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctrl.start |-> !div_busy)
        else $error("divider started while busy");

    // The overflow flag is sticky.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("overflow flag dropped");

endmodule

### rtl/pgbs_div.sv
module pgbs_div (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  pgbs_pkg::t_div_ctrl                              i_ctrl,
    input  logic [pgbs_pkg::COUNT_BITS-1:0]                  i_divisor,
    input  logic [pgbs_pkg::AXES-1:0][pgbs_pkg::SUMSQ_BITS-1:0] i_dividend,
    output logic                                             o_busy,
    output logic                                             o_done,
    output logic [pgbs_pkg::AXES-1:0][pgbs_pkg::SUMSQ_BITS-1:0] o_quot
);
    import pgbs_pkg::*;

    // Three restoring lanes sharing one divisor, one quotient bit per cycle.
    // The dividend shifts out at the top while quotient bits shift in below.
    logic [COUNT_BITS-1:0]                 r_div;
    logic [STEP_BITS-1:0]                  r_cnt;
    logic                                  r_busy;
    logic                                  r_done;
    logic [AXES-1:0][SUMSQ_BITS-1:0]       r_q;
    logic [AXES-1:0][COUNT_BITS-1:0]       r_rem;
    logic [AXES-1:0][COUNT_BITS:0]         trial;
    logic [AXES-1:0]                       take;
    logic [AXES-1:0][COUNT_BITS:0]         diff;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            trial[k] = {r_rem[k], r_q[k][SUMSQ_BITS-1]};
            take[k]  = trial[k] >= {1'b0, r_div};
            diff[k]  = trial[k] - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctrl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_div <= i_divisor;
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < AXES; k++) begin
                r_rem[k] <= take[k] ? diff[k][COUNT_BITS-1:0] : trial[k][COUNT_BITS-1:0];
                r_q[k]   <= {r_q[k][SUMSQ_BITS-2:0], take[k]};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
